// File: hw/rtl/gzp_pkg.sv
package gzp_pkg;

    localparam logic [7:0] MAGIC_ID1 = 8'h1f;
    localparam logic [7:0] MAGIC_ID2 = 8'h8b;
    localparam logic [7:0] METHOD_DEFLATE = 8'h08;

    localparam int FLAG_BIT_HCRC = 1;
    localparam int FLAG_BIT_EXTRA = 2;
    localparam int FLAG_BIT_NAME = 3;
    localparam int FLAG_BIT_COMMENT = 4;

    localparam int MIN_MEMBER = 18;
    localparam int FIXED_HEADER_LAST = 9;
    localparam int HCRC_BYTES = 2;
    localparam int TAIL_DEPTH = 8;

    localparam logic [31:0] MAX_OUTPUT_SIZE_RESET = 32'd8192;

    typedef enum logic [3:0] {
        PH_FIXED   = 4'd0,
        PH_XLEN_LO = 4'd1,
        PH_XLEN_HI = 4'd2,
        PH_EXTRA   = 4'd3,
        PH_NAME    = 4'd4,
        PH_COMMENT = 4'd5,
        PH_HCRC    = 4'd6,
        PH_BODY    = 4'd7,
        PH_ERROR   = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_HDR   = 3'd1,
        ST_TRUNCATED = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_TOO_LARGE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        SEC_FIXED   = 3'd0,
        SEC_EXTRA   = 3'd1,
        SEC_NAME    = 3'd2,
        SEC_COMMENT = 3'd3
    } section_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        done_res;
        status_t     status;
        logic [31:0] deflate_length;
        logic [31:0] expected_size;
    } result_t;

endpackage

// File: hw/rtl/gzip_header_trailer_parser_core.sv
// Channel   Direction  Beat contents
// s_axis    in         tdata = data_byte, tlast = last
// m_axis    out        tdata = payload_byte, status, deflate_length, expected_size;
//                      tuser = payload_valid, tlast = done_res
// cfg       in         cfg_data = max_output_size
//
// One input beat gives one output beat, registered and presented in the cycle after acceptance.
// The block takes one byte per cycle while its output is taken; only the output register sets the rate.
// A stalled output register holds its beat and stops input acceptance until it is taken.
// Reset returns the parser to the magic check and max_output_size to 8192.
module gzip_header_trailer_parser_core
    import gzp_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] status,
                                        // [42:11] deflate_length, [74:43] expected_size
    output logic        m_axis_tuser,   // [0] payload_valid
    output logic        m_axis_tlast
);

    logic [31:0] max_size_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     result;
    logic        advance;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign advance       = s_axis_tvalid && s_axis_tready;

    gzp_parser #(
        .COUNT_BITS(COUNT_BITS)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .data_byte      (s_axis_tdata),
        .last           (s_axis_tlast),
        .max_output_size(max_size_reg),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_size_reg  <= MAX_OUTPUT_SIZE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready)
                max_size_reg <= cfg_data;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.payload_valid;
    assign m_axis_tlast  = out_reg.done_res;
    assign m_axis_tdata  = {5'd0, out_reg.expected_size, out_reg.deflate_length,
                            out_reg.status, out_reg.payload_byte};

endmodule

// File: hw/rtl/gzp_parser.sv
module gzp_parser
    import gzp_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [7:0]  data_byte,
    input  logic        last,
    input  logic [31:0] max_output_size,
    output result_t     result
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    phase_t                phase_reg, phase_next;
    logic [7:0]            flags_reg, flags_next;
    logic [COUNT_BITS-1:0] pos_reg, pos_next;
    logic [15:0]           skip_reg, skip_next;
    logic [7:0]            xlen_lo_reg, xlen_lo_next;
    logic [7:0]            line_reg [TAIL_DEPTH];
    logic [7:0]            line_next [TAIL_DEPTH];
    logic [3:0]            fill_reg, fill_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  err_reg, err_next;

    logic [7:0]  magic_byte;
    logic [31:0] isize;

    function automatic phase_t section_after(input logic [7:0] flags, input section_t done);
        phase_t ph;
        if (done < SEC_EXTRA && flags[FLAG_BIT_EXTRA])
            ph = PH_XLEN_LO;
        else if (done < SEC_NAME && flags[FLAG_BIT_NAME])
            ph = PH_NAME;
        else if (done < SEC_COMMENT && flags[FLAG_BIT_COMMENT])
            ph = PH_COMMENT;
        else if (flags[FLAG_BIT_HCRC])
            ph = PH_HCRC;
        else
            ph = PH_BODY;
        return ph;
    endfunction

    always_comb
    begin
        case (pos_reg[1:0])
            2'd0:    magic_byte = MAGIC_ID1;
            2'd1:    magic_byte = MAGIC_ID2;
            default: magic_byte = METHOD_DEFLATE;
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        flags_next   = flags_reg;
        pos_next     = (pos_reg != CNT_MAX) ? pos_reg + COUNT_BITS'(1) : pos_reg;
        skip_next    = skip_reg;
        xlen_lo_next = xlen_lo_reg;
        line_next    = line_reg;
        fill_next    = fill_reg;
        count_next   = count_reg;
        err_next     = err_reg;
        result       = '0;
        isize        = '0;

        case (phase_reg)
            PH_FIXED:
            begin
                if (pos_reg <= COUNT_BITS'(2)) begin
                    if (data_byte != magic_byte) begin
                        err_next   = 1'b1;
                        phase_next = PH_ERROR;
                    end
                end else if (pos_reg == COUNT_BITS'(3)) begin
                    flags_next = data_byte;
                end else if (pos_reg >= COUNT_BITS'(FIXED_HEADER_LAST)) begin
                    phase_next = section_after(flags_reg, SEC_FIXED);
                end
            end
            PH_XLEN_LO:
            begin
                xlen_lo_next = data_byte;
                phase_next   = PH_XLEN_HI;
            end
            PH_XLEN_HI:
            begin
                skip_next  = {data_byte, xlen_lo_reg};
                phase_next = ({data_byte, xlen_lo_reg} != 16'd0) ? PH_EXTRA
                           : section_after(flags_reg, SEC_EXTRA);
            end
            PH_EXTRA:
            begin
                skip_next = skip_reg - 16'd1;
                if (skip_reg == 16'd1)
                    phase_next = section_after(flags_reg, SEC_EXTRA);
            end
            PH_NAME:
            begin
                if (data_byte == 8'd0)
                    phase_next = section_after(flags_reg, SEC_NAME);
            end
            PH_COMMENT:
            begin
                if (data_byte == 8'd0)
                    phase_next = section_after(flags_reg, SEC_COMMENT);
            end
            PH_HCRC:
            begin
                skip_next = skip_reg - 16'd1;
                if (skip_reg == 16'd1)
                    phase_next = PH_BODY;
            end
            PH_BODY:
            begin
                if (fill_reg[3]) begin
                    result.payload_valid = 1'b1;
                    result.payload_byte  = line_reg[0];
                    for (int i = 0; i < TAIL_DEPTH - 1; i++)
                        line_next[i] = line_reg[i+1];
                    line_next[TAIL_DEPTH-1] = data_byte;
                    if (count_reg != CNT_MAX)
                        count_next = count_reg + COUNT_BITS'(1);
                end else begin
                    line_next[fill_reg[2:0]] = data_byte;
                    fill_next = fill_reg + 4'd1;
                end
            end
            default:
            begin
                phase_next = PH_ERROR;
            end
        endcase

        // Every entry into the header CRC skip starts a two-byte count.
        if (phase_next == PH_HCRC && phase_reg != PH_HCRC)
            skip_next = 16'(HCRC_BYTES);

        if (last) begin
            result.done_res = 1'b1;
            isize = {line_next[7], line_next[6], line_next[5], line_next[4]};
            if (pos_reg < COUNT_BITS'(MIN_MEMBER - 1)) begin
                result.status = ST_TRUNCATED;
            end else if (err_next) begin
                result.status = ST_BAD_HDR;
            end else if (phase_next != PH_BODY || !fill_next[3]) begin
                result.status = ST_TRUNCATED;
            end else begin
                result.expected_size  = isize;
                result.deflate_length = 32'(count_next);
                if (isize == 32'd0)
                    result.status = ST_EMPTY;
                else if (isize > max_output_size)
                    result.status = ST_TOO_LARGE;
                else
                    result.status = ST_OK;
            end

            phase_next   = PH_FIXED;
            flags_next   = '0;
            pos_next     = '0;
            skip_next    = '0;
            xlen_lo_next = '0;
            fill_next    = '0;
            count_next   = '0;
            err_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= PH_FIXED;
            flags_reg   <= '0;
            pos_reg     <= '0;
            skip_reg    <= '0;
            xlen_lo_reg <= '0;
            fill_reg    <= '0;
            count_reg   <= '0;
            err_reg     <= 1'b0;
        end else if (advance) begin
            phase_reg   <= phase_next;
            flags_reg   <= flags_next;
            pos_reg     <= pos_next;
            skip_reg    <= skip_next;
            xlen_lo_reg <= xlen_lo_next;
            fill_reg    <= fill_next;
            count_reg   <= count_next;
            err_reg     <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            line_reg <= line_next;
    end

endmodule

// File: hw/rtl/gzp_checker.sv
module gzp_checker
    import gzp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // Summary fields stay zero on every beat that does not close a member.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[74:8] == 67'd0)
        else $error("summary fields set before the final beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[10:8] <= ST_TOO_LARGE)
        else $error("status code out of range");

    // A failed parse reports no lengths.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[10:8] == ST_BAD_HDR || m_axis_tdata[10:8] == ST_TRUNCATED)
        |-> m_axis_tdata[74:11] == 64'd0)
        else $error("lengths reported on a failed parse");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted input beat produced no output beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

endmodule

bind gzip_header_trailer_parser_core gzp_checker u_gzp_checker (.*);
